### rtl/rgtd_pkg.sv
// ----------------------------------------------------------------------------
// rgtd_pkg
// Shared constants, codes and the command type of the RDS group text decoder.
// ----------------------------------------------------------------------------
package rgtd_pkg;

  // String lengths and index widths.
  localparam int NAME_CHARS = 8;
  localparam int TEXT_CHARS = 64;
  localparam int NAME_IDX_W = $clog2(NAME_CHARS);
  localparam int TEXT_IDX_W = $clog2(TEXT_CHARS);
  localparam int CHAR_W     = 8;

  localparam logic [TEXT_IDX_W-1:0] NAME_LAST_IDX = TEXT_IDX_W'(NAME_CHARS - 1);
  localparam logic [TEXT_IDX_W-1:0] TEXT_LAST_IDX = TEXT_IDX_W'(TEXT_CHARS - 1);

  // Stream widths.
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;
  localparam int KIND_W     = 2;

  // Group types handled and segment limits.
  localparam logic [3:0] GT_NAME       = 4'd0;
  localparam logic [3:0] GT_TEXT       = 4'd2;
  localparam logic [1:0] NAME_LAST_SEG = 2'd3;
  localparam logic [3:0] TEXT_LAST_SEG = 4'd15;
  localparam logic [CHAR_W-1:0] CR_CODE = 8'd13;

  // Command codes from the front end to the back end.
  localparam logic [1:0] OP_STATUS = 2'd0;
  localparam logic [1:0] OP_NAME   = 2'd1;
  localparam logic [1:0] OP_TEXT   = 2'd2;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NAME   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TEXT   = 2'd2;

  // Content kinds.
  localparam logic [1:0] CONTENT_TRAFFIC = 2'd0;
  localparam logic [1:0] CONTENT_MUSIC   = 2'd1;
  localparam logic [1:0] CONTENT_SPEECH  = 2'd2;

  // Command queue depth (a power of two so the pointers wrap on their own).
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // One classified group, as handed from the front end to the back end.
  typedef struct packed {
    logic [1:0]                  op;
    logic                        complete;
    logic                        wide;
    logic [TEXT_IDX_W-1:0]       pos;
    logic [3:0][CHAR_W-1:0]      chars;
    logic [3:0]                  gtype;
    logic                        gver;
    logic [4:0]                  pt;
    logic                        tp;
    logic                        ta;
    logic                        ms;
  } cmd_t;

endpackage

### rtl/rds_group_text_decoder_core.sv
// ----------------------------------------------------------------------------
// rds_group_text_decoder_core
// RDS group decoder for station name and radiotext with per-group status.
// ----------------------------------------------------------------------------
// Each input word is one RDS group (blocks B, C, D). A front end updates the
// program type and traffic and music flags, checks the segment order and
// places a command in a two-entry queue, so it keeps taking groups while the
// back end works. The back end stores the characters, then either gives one
// status word or, when the station name or radiotext completes, emits the
// whole string, one character word per cycle while the receiver is ready,
// and clears it. A dropped or unsupported group gives only a status word.
// A name group writes its two characters into the name buffer; a radiotext
// group writes its two or four characters one at a time into the radiotext
// RAM, which is read back through its single read port.
module rds_group_text_decoder_core import rgtd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // block_b [15:0], block_c [31:16], block_d [47:32]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // char_index [5:0], char_value [13:6], program_type [18:14],
  // traffic_program [19], traffic_announcement [20], music_flag [21],
  // content_kind [23:22], group_type [27:24], group_version [28],
  // group_supported [29], zero fill [31:30]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  // result_kind [1:0]
  output logic [KIND_W-1:0]     out_tuser
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  rgtd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  rgtd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  rgtd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

### rtl/rgtd_ram.sv
// ----------------------------------------------------------------------------
// rgtd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rgtd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port; a read of the address being written returns the old word.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/rgtd_front.sv
// ----------------------------------------------------------------------------
// rgtd_front
// Accepts groups, updates the flag and segment state and classifies each
// group into one command for the back end.
// ----------------------------------------------------------------------------
module rgtd_front import rgtd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 q_full,
  output logic                 q_push,
  output cmd_t                 q_cmd
);

  logic [15:0] blk_b;
  logic [15:0] blk_c;
  logic [15:0] blk_d;
  logic        accept;

  // TP and program type are taken from every group, so they need no storage here.
  logic        grp_tp;
  logic [4:0]  grp_pt;
  logic        ta_r, ta_nxt;
  logic        ms_r, ms_nxt;
  logic [1:0]  name_seg_r, name_seg_nxt;
  logic [3:0]  text_seg_r, text_seg_nxt;

  assign blk_b     = in_tdata[15:0];
  assign blk_c     = in_tdata[31:16];
  assign blk_d     = in_tdata[47:32];
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign q_push    = accept;

  // Classify the group and work out the state it leaves behind.
  always_comb begin
    logic found;
    found        = 1'b0;
    grp_tp       = blk_b[10];
    grp_pt       = blk_b[9:5];
    ta_nxt       = ta_r;
    ms_nxt       = ms_r;
    name_seg_nxt = name_seg_r;
    text_seg_nxt = text_seg_r;
    q_cmd        = '0;
    q_cmd.op     = OP_STATUS;
    q_cmd.gtype  = blk_b[15:12];
    q_cmd.gver   = blk_b[11];

    if (blk_b[15:12] == GT_NAME) begin
      ms_nxt = blk_b[3];
      ta_nxt = blk_b[4];
      if (blk_b[1:0] != name_seg_r) begin
        name_seg_nxt = 2'd0;
      end else begin
        q_cmd.op       = OP_NAME;
        q_cmd.pos      = {{(TEXT_IDX_W - 3){1'b0}}, blk_b[1:0], 1'b0};
        q_cmd.chars[0] = blk_d[15:8];
        q_cmd.chars[1] = blk_d[7:0];
        q_cmd.complete = (blk_b[1:0] == NAME_LAST_SEG);
        name_seg_nxt   = q_cmd.complete ? 2'd0 : blk_b[1:0] + 2'd1;
      end
    end else if (blk_b[15:12] == GT_TEXT) begin
      if (blk_b[3:0] != text_seg_r) begin
        text_seg_nxt = 4'd0;
      end else begin
        q_cmd.op   = OP_TEXT;
        q_cmd.wide = !blk_b[11];
        if (q_cmd.wide) begin
          q_cmd.chars[0] = blk_c[15:8];
          q_cmd.chars[1] = blk_c[7:0];
          q_cmd.chars[2] = blk_d[15:8];
          q_cmd.chars[3] = blk_d[7:0];
          q_cmd.pos      = {blk_b[3:0], 2'b00};
        end else begin
          q_cmd.chars[0] = blk_d[15:8];
          q_cmd.chars[1] = blk_d[7:0];
          q_cmd.pos      = {1'b0, blk_b[3:0], 1'b0};
        end
        // The first carriage return ends the text and is stored as zero.
        for (int p = 0; p < 4; p++) begin
          if (!found && (q_cmd.wide || p < 2) && q_cmd.chars[p] == CR_CODE) begin
            q_cmd.chars[p] = '0;
            found          = 1'b1;
          end
        end
        q_cmd.complete = found || (blk_b[3:0] == TEXT_LAST_SEG);
        text_seg_nxt   = q_cmd.complete ? 4'd0 : blk_b[3:0] + 4'd1;
      end
    end

    q_cmd.tp = grp_tp;
    q_cmd.pt = grp_pt;
    q_cmd.ta = ta_nxt;
    q_cmd.ms = ms_nxt;
  end

  // Flag and segment state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ta_r       <= 1'b0;
      ms_r       <= 1'b0;
      name_seg_r <= '0;
      text_seg_r <= '0;
    end else if (accept) begin
      ta_r       <= ta_nxt;
      ms_r       <= ms_nxt;
      name_seg_r <= name_seg_nxt;
      text_seg_r <= text_seg_nxt;
    end
  end

endmodule

### rtl/rgtd_queue.sv
// ----------------------------------------------------------------------------
// rgtd_queue
// Short command queue that lets the front end and the back end stall apart.
// ----------------------------------------------------------------------------
module rgtd_queue import rgtd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  cmd_t                   slot_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r;
  logic [QUEUE_CNT_W-1:0] cnt_r;

  assign full    = (cnt_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_cmd = slot_r[rd_ptr_r];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QUEUE_CNT_W'(1);
      end
    end
  end

  // The count never goes beyond the depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("command queue overfilled");

  // The back end never pops an empty queue.
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("pop from empty command queue");

endmodule

### rtl/rgtd_back.sv
// ----------------------------------------------------------------------------
// rgtd_back
// Carries out commands: stores characters, emits completed strings one
// character per word and gives status words.
// ----------------------------------------------------------------------------
module rgtd_back import rgtd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  cmd_t                  q_cmd,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  output logic [KIND_W-1:0]     out_tuser
);

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [TEXT_IDX_W-1:0] char_index;
    logic [CHAR_W-1:0]     char_value;
    logic                  last;
    logic [4:0]            pt;
    logic                  tp;
    logic                  ta;
    logic                  ms;
    logic [1:0]            content;
    logic [3:0]            gtype;
    logic                  gver;
    logic                  supported;
  } res_t;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_WRITE  = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;
  localparam logic [1:0] ST_STATUS = 2'd3;

  logic [1:0]            state_r, state_nxt;
  cmd_t                  cur_r;
  logic [1:0]            wr_cnt_r;
  logic [TEXT_IDX_W-1:0] emit_idx_r;
  logic [CHAR_W-1:0]     name_buf_r [NAME_CHARS];
  logic [TEXT_CHARS-1:0] txt_vld_r;

  logic                  ch_valid_r;
  logic [TEXT_IDX_W-1:0] ch_idx_r;
  logic                  ch_last_r;
  logic [CHAR_W-1:0]     ch_name_val_r;
  logic                  ch_txt_vld_r;

  logic                  out_valid_r;
  res_t                  out_res_r;
  res_t                  res_nxt;

  logic                  out_free;
  logic                  ch_load;
  logic                  stat_load;
  logic                  issue;
  logic                  emit_last;
  logic                  wr_done;
  logic                  ram_we;
  logic [TEXT_IDX_W-1:0] ram_waddr;
  logic                  ram_re;
  logic [CHAR_W-1:0]     ram_rdata;

  // Handshake and sequencing conditions.
  assign out_free  = !out_valid_r || out_tready;
  assign ch_load   = ch_valid_r && out_free;
  assign stat_load = (state_r == ST_STATUS) && out_free;
  assign emit_last = emit_idx_r == ((cur_r.op == OP_NAME) ? NAME_LAST_IDX : TEXT_LAST_IDX);
  assign issue     = (state_r == ST_EMIT) && (!ch_valid_r || ch_load);
  assign q_pop     = (state_r == ST_IDLE) && !q_empty && !ch_valid_r;
  assign wr_done   = (cur_r.op == OP_NAME) || (wr_cnt_r == (cur_r.wide ? 2'd3 : 2'd1));

  // Radiotext store.
  assign ram_we    = (state_r == ST_WRITE) && (cur_r.op == OP_TEXT);
  assign ram_waddr = cur_r.pos + TEXT_IDX_W'(wr_cnt_r);
  assign ram_re    = issue && (cur_r.op == OP_TEXT);

  rgtd_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (TEXT_CHARS)
  ) u_text_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cur_r.chars[wr_cnt_r]),
    .re    (ram_re),
    .raddr (emit_idx_r),
    .rdata (ram_rdata)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          state_nxt = (q_cmd.op == OP_STATUS) ? ST_STATUS : ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (wr_done) begin
          state_nxt = cur_r.complete ? ST_EMIT : ST_STATUS;
        end
      end
      ST_EMIT: begin
        if (issue && emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_STATUS: begin
        if (stat_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Current command and its counters.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r      <= q_cmd;
      wr_cnt_r   <= '0;
      emit_idx_r <= '0;
    end else begin
      if (state_r == ST_WRITE) begin
        wr_cnt_r <= wr_cnt_r + 2'd1;
      end
      if (issue) begin
        emit_idx_r <= emit_idx_r + TEXT_IDX_W'(1);
      end
    end
  end

  // Station name buffer; cleared once its last character has been read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NAME_CHARS; i++) begin
        name_buf_r[i] <= '0;
      end
    end else if (issue && emit_last && cur_r.op == OP_NAME) begin
      for (int i = 0; i < NAME_CHARS; i++) begin
        name_buf_r[i] <= '0;
      end
    end else if (state_r == ST_WRITE && cur_r.op == OP_NAME) begin
      name_buf_r[cur_r.pos[NAME_IDX_W-1:0]]                  <= cur_r.chars[0];
      name_buf_r[cur_r.pos[NAME_IDX_W-1:0] + NAME_IDX_W'(1)] <= cur_r.chars[1];
    end
  end

  // Radiotext valid bits; an entry not written since the last clear reads zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      txt_vld_r <= '0;
    end else if (issue && emit_last && cur_r.op == OP_TEXT) begin
      txt_vld_r <= '0;
    end else if (ram_we) begin
      txt_vld_r[ram_waddr] <= 1'b1;
    end
  end

  // Character stage, aligned with the registered RAM read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_valid_r <= 1'b0;
    end else if (issue) begin
      ch_valid_r <= 1'b1;
    end else if (ch_load) begin
      ch_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      ch_idx_r      <= emit_idx_r;
      ch_last_r     <= emit_last;
      ch_name_val_r <= name_buf_r[emit_idx_r[NAME_IDX_W-1:0]];
      ch_txt_vld_r  <= txt_vld_r[emit_idx_r];
    end
  end

  // Next result word.
  always_comb begin
    res_nxt            = '0;
    res_nxt.kind       = KIND_STATUS;
    res_nxt.last       = 1'b1;
    if (ch_load) begin
      res_nxt.kind       = (cur_r.op == OP_TEXT) ? KIND_TEXT : KIND_NAME;
      res_nxt.char_index = ch_idx_r;
      res_nxt.last       = ch_last_r;
      if (cur_r.op == OP_TEXT) begin
        res_nxt.char_value = ch_txt_vld_r ? ram_rdata : '0;
      end else begin
        res_nxt.char_value = ch_name_val_r;
      end
    end
    res_nxt.pt        = cur_r.pt;
    res_nxt.tp        = cur_r.tp;
    res_nxt.ta        = cur_r.ta;
    res_nxt.ms        = cur_r.ms;
    if (cur_r.ta && cur_r.tp) begin
      res_nxt.content = CONTENT_TRAFFIC;
    end else if (cur_r.ms) begin
      res_nxt.content = CONTENT_MUSIC;
    end else begin
      res_nxt.content = CONTENT_SPEECH;
    end
    res_nxt.gtype     = cur_r.gtype;
    res_nxt.gver      = cur_r.gver;
    res_nxt.supported = (cur_r.gtype == GT_NAME) || (cur_r.gtype == GT_TEXT);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ch_load || stat_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ch_load || stat_load) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_res_r.last;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {2'b00, out_res_r.supported, out_res_r.gver, out_res_r.gtype,
                       out_res_r.content, out_res_r.ms, out_res_r.ta, out_res_r.tp,
                       out_res_r.pt, out_res_r.char_value, out_res_r.char_index};

  // A status word is never given while a character is still on its way out.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STATUS) |-> !ch_valid_r)
    else $error("status word would overtake a pending character");

  // Name emission stays within the name buffer.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && cur_r.op == OP_NAME) |-> (emit_idx_r < TEXT_IDX_W'(NAME_CHARS)))
    else $error("name emission index out of range");

  // The radiotext is empty again right after its last character is read.
  assert property (@(posedge clk) disable iff (!rst_n)
    (issue && emit_last && cur_r.op == OP_TEXT) |=> (txt_vld_r == '0))
    else $error("radiotext not cleared after emission");

endmodule
